>>> rtl/command_frame_deframer_seq_check_macros.svh
// Assertion helpers; clk and rst_n are taken from the scope of the use.
`ifndef COMMAND_FRAME_DEFRAMER_SEQ_CHECK_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_SEQ_CHECK_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CFDS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CFDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cfds_pkg.sv
`default_nettype none
package cfds_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int POS_W       = 4;
  localparam int SLOT_W      = 3;
  localparam int NUM_SLOTS   = 6;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = 2;

  localparam logic [7:0] HDR_BYTE = 8'h81;
  localparam logic [7:0] FTR_BYTE = 8'h88;

  localparam logic [7:0] TYPE_PUSH    = 8'h04;
  localparam logic [7:0] TYPE_STOP    = 8'h20;
  localparam logic [7:0] TYPE_FWD     = 8'h21;
  localparam logic [7:0] TYPE_BACK    = 8'h22;
  localparam logic [7:0] TYPE_LEFT    = 8'h23;
  localparam logic [7:0] TYPE_RIGHT   = 8'h24;

  localparam logic [SLOT_W-1:0] SLOT_PUSH  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_STOP  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_FWD   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_BACK  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_LEFT  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT = 3'd5;

  localparam logic [31:0] WORD_STRAIGHT = 32'hFF00_0000;
  localparam logic [31:0] WORD_TURN     = 32'hF0F0_0000;

  localparam logic [POS_W-1:0] RPL_RC_HI = 4'd3;
  localparam logic [POS_W-1:0] RPL_RC_LO = 4'd4;
  localparam logic [POS_W-1:0] RPL_LAST  = 4'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_MOTION = 2'd0,
    KIND_PUSH   = 2'd1,
    KIND_REPLY  = 2'd2
  } out_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_REPLY
  } back_state_t;

  // One checked frame waiting for execution
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [15:0]       seq;
    logic [15:0]       pair;
  } job_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  // Check that a frame type is known, and map it to its counter slot
  function automatic logic type_known(input logic [7:0] t);
    return (t == TYPE_PUSH) || (t == TYPE_STOP) || (t == TYPE_FWD) ||
           (t == TYPE_BACK) || (t == TYPE_LEFT) || (t == TYPE_RIGHT);
  endfunction

  function automatic logic [SLOT_W-1:0] type_slot(input logic [7:0] t);
    logic [SLOT_W-1:0] s;
    s = SLOT_PUSH;
    unique case (t)
      TYPE_STOP:  s = SLOT_STOP;
      TYPE_FWD:   s = SLOT_FWD;
      TYPE_BACK:  s = SLOT_BACK;
      TYPE_LEFT:  s = SLOT_LEFT;
      TYPE_RIGHT: s = SLOT_RIGHT;
      default:    s = SLOT_PUSH;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] slot_letter(input logic [SLOT_W-1:0] s);
    logic [7:0] l;
    unique case (s)
      SLOT_STOP:  l = "S";
      SLOT_FWD:   l = "F";
      SLOT_BACK:  l = "B";
      SLOT_LEFT:  l = "L";
      SLOT_RIGHT: l = "R";
      default:    l = 8'h00;
    endcase
    return l;
  endfunction

  function automatic logic [31:0] slot_word(input logic [SLOT_W-1:0] s,
                                            input logic [15:0] pair);
    logic [31:0] w;
    unique case (s)
      SLOT_STOP:             w = WORD_STRAIGHT;
      SLOT_FWD, SLOT_BACK:   w = WORD_STRAIGHT | {16'h0000, pair};
      SLOT_LEFT, SLOT_RIGHT: w = WORD_TURN | {16'h0000, pair};
      default:               w = 32'h0000_0000;
    endcase
    return w;
  endfunction

  // Error reply frame: 81 'M' 06 rc_hi rc_lo 'C' 'O' 'F' 'F' 88
  function automatic logic [7:0] reply_at(input logic [POS_W-1:0] idx,
                                          input logic [15:0] rc);
    logic [7:0] b;
    unique case (idx)
      4'd0:      b = HDR_BYTE;
      4'd1:      b = "M";
      4'd2:      b = 8'h06;
      RPL_RC_HI: b = rc[15:8];
      RPL_RC_LO: b = rc[7:0];
      4'd5:      b = "C";
      4'd6:      b = "O";
      4'd7:      b = "F";
      4'd8:      b = "F";
      default:   b = FTR_BYTE;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cfds_if.sv
`default_nettype none
interface cfds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [31:0] command_word;
  logic [7:0]  command_letter;
  logic [7:0]  reply_byte;
  logic        last;

  modport source (output valid, output out_kind, output command_word,
                  output command_letter, output reply_byte, output last,
                  input ready);
  modport sink   (input valid, input out_kind, input command_word,
                  input command_letter, input reply_byte, input last,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/cfds_front.sv
`default_nettype none
module cfds_front
  import cfds_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_vld,
  input  wire logic [7:0] byte_in,
  output logic            push,
  output job_t            push_job
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      pair_r, pair_nxt;

  // Walk the frame one byte at a time
  always_comb begin
    pos_nxt  = pos_r;
    type_nxt = type_r;
    seq_nxt  = seq_r;
    pair_nxt = pair_r;
    push     = 1'b0;
    if (byte_vld) begin
      if (pos_r == '0 || pos_r >= POS_W'(FRAME_BYTES)) begin
        pos_nxt = (byte_in == HDR_BYTE) ? POS_W'(1) : '0;
      end else begin
        unique case (pos_r)
          4'd2:    type_nxt = byte_in;
          4'd3:    seq_nxt  = {byte_in, seq_r[7:0]};
          4'd4:    seq_nxt  = {seq_r[15:8], byte_in};
          4'd5:    pair_nxt = {byte_in, pair_r[7:0]};
          4'd6:    pair_nxt = {pair_r[15:8], byte_in};
          default: ;
        endcase
        if (pos_r == POS_W'(FRAME_BYTES - 1)) begin
          pos_nxt = '0;
          // hand a complete frame of known type to the job queue
          push    = (byte_in == FTR_BYTE) && type_known(type_r);
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  assign push_job.slot = type_slot(type_r);
  assign push_job.seq  = seq_r;
  assign push_job.pair = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      type_r <= '0;
      seq_r  <= '0;
      pair_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      seq_r  <= seq_nxt;
      pair_r <= pair_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfds_queue.sv
`default_nettype none
module cfds_queue
  import cfds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_head_t head
);

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  // Store entries at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + (Q_AW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (Q_AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfds_back.sv
`default_nettype none
module cfds_back
  import cfds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_head_t head,
  output logic           pop,
  cfds_out_if.source     out_ch
);

  back_state_t      state_r, state_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [15:0]      cnt_r [NUM_SLOTS];
  logic [15:0]      rc_r, rc_nxt;

  logic             out_vld_r, out_vld_nxt;
  out_kind_t        kind_r, kind_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [7:0]       letter_r, letter_nxt;
  logic [7:0]       rbyte_r, rbyte_nxt;
  logic             last_r, last_nxt;

  logic             can_load;
  logic [15:0]      cnt_inc;
  logic             seq_ok;
  logic             cnt_we;
  logic [15:0]      cnt_wdata;

  assign can_load = !out_vld_r || out_ch.ready;
  assign cnt_inc  = cnt_r[head.job.slot] + 16'd1;
  assign seq_ok   = (cnt_inc == head.job.seq);

  // Execute queued frames and sequence the reply bytes
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    rc_nxt      = rc_r;
    out_vld_nxt = out_vld_r;
    kind_nxt    = kind_r;
    word_nxt    = word_r;
    letter_nxt  = letter_r;
    rbyte_nxt   = rbyte_r;
    last_nxt    = last_r;
    pop         = 1'b0;
    cnt_we      = 1'b0;
    cnt_wdata   = head.job.seq;
    if (out_vld_r && out_ch.ready) out_vld_nxt = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid && can_load) begin
          pop         = 1'b1;
          cnt_we      = 1'b1;
          out_vld_nxt = 1'b1;
          if (seq_ok) begin
            cnt_wdata = cnt_inc;
            last_nxt  = 1'b1;
            rbyte_nxt = 8'h00;
            if (head.job.slot == SLOT_PUSH) begin
              kind_nxt   = KIND_PUSH;
              word_nxt   = 32'h0000_0000;
              letter_nxt = head.job.pair[15:8];
            end else begin
              kind_nxt   = KIND_MOTION;
              word_nxt   = slot_word(head.job.slot, head.job.pair);
              letter_nxt = slot_letter(head.job.slot);
            end
          end else begin
            // resync the counter and start the error reply
            cnt_wdata  = head.job.seq;
            rc_nxt     = rc_r + 16'd1;
            kind_nxt   = KIND_REPLY;
            word_nxt   = 32'h0000_0000;
            letter_nxt = 8'h00;
            rbyte_nxt  = reply_at('0, rc_r + 16'd1);
            last_nxt   = 1'b0;
            idx_nxt    = POS_W'(1);
            state_nxt  = BK_REPLY;
          end
        end
      end
      BK_REPLY: begin
        if (can_load) begin
          out_vld_nxt = 1'b1;
          rbyte_nxt   = reply_at(idx_r, rc_r);
          last_nxt    = (idx_r == RPL_LAST);
          idx_nxt     = idx_r + POS_W'(1);
          if (idx_r == RPL_LAST) state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      idx_r     <= '0;
      rc_r      <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) cnt_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      rc_r      <= rc_nxt;
      out_vld_r <= out_vld_nxt;
      if (cnt_we) cnt_r[head.job.slot] <= cnt_wdata;
    end
  end

  // Output payload holds while stalled
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    word_r   <= word_nxt;
    letter_r <= letter_nxt;
    rbyte_r  <= rbyte_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.out_kind       = kind_r;
  assign out_ch.command_word   = word_r;
  assign out_ch.command_letter = letter_r;
  assign out_ch.reply_byte     = rbyte_r;
  assign out_ch.last           = last_r;

endmodule
`default_nettype wire

>>> rtl/command_frame_deframer_seq_check.sv
// Throughput: one received byte per cycle; input stalls only when the 4-entry job queue is full.
// The job queue is written at the edge that accepts the footer byte, and the output register
// loads from the queue head once the back end is idle and the output can take a new result.
// A sequence error emits 10 reply results from the reply byte sequencer, one per cycle while the output is not stalled.
// Reset (rst_n low, synchronous): frame position, type counters, reply counter,
// job queue and output valid all clear; no clearing pass is needed.
`default_nettype none
`include "command_frame_deframer_seq_check_macros.svh"
module command_frame_deframer_seq_check
  import cfds_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  cfds_in_if.sink    in_ch,
  cfds_out_if.source out_ch
);

  logic      push;
  job_t      push_job;
  logic      q_full;
  logic      pop;
  job_head_t head;
  logic      in_acc;

  // Accept bytes whenever a finished frame has room in the queue
  assign in_ch.ready = !q_full;
  assign in_acc      = in_ch.valid && !q_full;

  cfds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .byte_in  (in_ch.rx_byte),
    .push     (push),
    .push_job (push_job)
  );

  cfds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  cfds_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `CFDS_ASSERT_ALWAYS(a_no_push_full, !(push && q_full), "job pushed into full queue")
  `CFDS_ASSERT_IMP(a_pop_has_job, pop, head.valid, "pop from empty queue")
  `CFDS_ASSERT_IMP(a_cmd_is_last, out_ch.valid && out_ch.out_kind != KIND_REPLY, out_ch.last, "command result without last")
  `CFDS_ASSERT_IMP(a_reply_ends_ftr, out_ch.valid && out_ch.out_kind == KIND_REPLY && out_ch.last, out_ch.reply_byte == FTR_BYTE, "reply frame ends without footer")

endmodule
`default_nettype wire

>>> dv/cfds_frame_checker.sv
`default_nettype none
module cfds_frame_checker
  import cfds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  cfds_in_if        in_ch,
  cfds_out_if       out_ch,
  output int        error_count,
  output int        expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  // Index of the next expected frame byte
  localparam logic [POS_W-1:0] POS_IDLE    = 4'd0;
  localparam logic [POS_W-1:0] POS_DEST    = 4'd1;
  localparam logic [POS_W-1:0] POS_TYPE    = 4'd2;
  localparam logic [POS_W-1:0] POS_SEQ_HI  = 4'd3;
  localparam logic [POS_W-1:0] POS_SEQ_LO  = 4'd4;
  localparam logic [POS_W-1:0] POS_DATA1   = 4'd5;
  localparam logic [POS_W-1:0] POS_DATA2   = 4'd6;
  localparam logic [POS_W-1:0] POS_FOOTER  = 4'(FRAME_BYTES - 1);
  localparam int               SHOWN_MAX   = 10;

  typedef struct packed {
    out_kind_t   kind;
    logic [31:0] word;
    logic [7:0]  letter;
    logic [7:0]  rbyte;
    logic        last;
  } deframed_t;

  // Shadow of the deframer state
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_type;
  logic [15:0]      frame_seq;
  logic [15:0]      frame_pair;
  logic [15:0]      seq_count [NUM_SLOTS];
  logic [15:0]      nack_count;

  deframed_t pending_results [$];

  // Advance the shadow deframer by one byte and queue what it emits
  task automatic deframe_byte(input logic [7:0] b);
    logic [SLOT_W-1:0] slot;
    logic [31:0]       word;
    logic [7:0]        letter;
    logic              known;
    logic [15:0]       bumped;
    logic [79:0]       nack;
    deframed_t         res;

    if (frame_pos == POS_IDLE || frame_pos > POS_FOOTER) begin
      frame_pos = (b == HDR_BYTE) ? POS_DEST : POS_IDLE;
      return;
    end

    case (frame_pos)
      POS_TYPE:   frame_type = b;
      POS_SEQ_HI: frame_seq[15:8] = b;
      POS_SEQ_LO: frame_seq[7:0] = b;
      POS_DATA1:  frame_pair[15:8] = b;
      POS_DATA2:  frame_pair[7:0] = b;
      default: ;
    endcase

    if (frame_pos != POS_FOOTER) begin
      frame_pos = frame_pos + 4'd1;
      return;
    end

    // Footer: drop on a bad one, else dispatch by type
    frame_pos = POS_IDLE;
    if (b != FTR_BYTE) return;

    known = 1'b1;
    slot = SLOT_PUSH;
    word = 32'h0;
    letter = 8'h00;
    case (frame_type)
      TYPE_PUSH: begin
        slot = SLOT_PUSH;  letter = frame_pair[15:8];
      end
      TYPE_STOP: begin
        slot = SLOT_STOP;  word = WORD_STRAIGHT; letter = "S";
      end
      TYPE_FWD: begin
        slot = SLOT_FWD;   word = WORD_STRAIGHT | {16'h0000, frame_pair}; letter = "F";
      end
      TYPE_BACK: begin
        slot = SLOT_BACK;  word = WORD_STRAIGHT | {16'h0000, frame_pair}; letter = "B";
      end
      TYPE_LEFT: begin
        slot = SLOT_LEFT;  word = WORD_TURN | {16'h0000, frame_pair}; letter = "L";
      end
      TYPE_RIGHT: begin
        slot = SLOT_RIGHT; word = WORD_TURN | {16'h0000, frame_pair}; letter = "R";
      end
      default: known = 1'b0;
    endcase
    if (!known) return;

    bumped = seq_count[slot] + 16'd1;
    if (bumped == frame_seq) begin
      seq_count[slot] = bumped;
      res.kind   = (slot == SLOT_PUSH) ? KIND_PUSH : KIND_MOTION;
      res.word   = word;
      res.letter = letter;
      res.rbyte  = 8'h00;
      res.last   = 1'b1;
      pending_results.push_back(res);
      return;
    end

    // Sequence error: resync the counter and queue the error reply
    seq_count[slot] = frame_seq;
    nack_count = nack_count + 16'd1;
    nack = {HDR_BYTE, "M", 8'h06, nack_count, "COFF", FTR_BYTE};
    for (int i = 0; i < FRAME_BYTES; i++) begin
      res.kind   = KIND_REPLY;
      res.word   = 32'h0;
      res.letter = 8'h00;
      res.rbyte  = nack[79 - 8*i -: 8];
      res.last   = (i == FRAME_BYTES - 1);
      pending_results.push_back(res);
    end
  endtask

  // Track accepted bytes, compare each accepted result with the oldest expectation
  always @(posedge clk) begin : watch
    deframed_t got;
    deframed_t want;

    if (!rst_n) begin
      frame_pos  = POS_IDLE;
      frame_type = 8'h00;
      frame_seq  = 16'h0;
      frame_pair = 16'h0;
      nack_count = 16'h0;
      foreach (seq_count[i]) seq_count[i] = 16'h0;
      pending_results.delete();
      expected_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);

      if (out_ch.valid && out_ch.ready) begin
        got.kind   = out_kind_t'(out_ch.out_kind);
        got.word   = out_ch.command_word;
        got.letter = out_ch.command_letter;
        got.rbyte  = out_ch.reply_byte;
        got.last   = out_ch.last;
        if (pending_results.size() == 0) begin
          if (error_count < SHOWN_MAX)
            $display("%0t: unexpected result kind %0d word %h letter %h reply %h last %b",
                     $realtime, got.kind, got.word, got.letter, got.rbyte, got.last);
          error_count <= error_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.word !== want.word ||
              got.letter !== want.letter || got.rbyte !== want.rbyte ||
              got.last !== want.last) begin
            if (error_count < SHOWN_MAX) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected kind %0d word %h letter %h reply %h last %b",
                       want.kind, want.word, want.letter, want.rbyte, want.last);
              $display("  actual   kind %0d word %h letter %h reply %h last %b",
                       got.kind, got.word, got.letter, got.rbyte, got.last);
            end
            error_count <= error_count + 1;
          end
        end
      end
      expected_left <= pending_results.size();
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
module tb_top
  import cfds_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 410;
  localparam int GAP_MAX      = 14;
  localparam int SETTLE       = 20;

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   error_count;
  int   expected_left;
  int   bytes_sent;

  // Last sequence number taken by each type counter, to aim frames at a match
  logic [15:0] last_seq [NUM_SLOTS];

  cfds_in_if  in_ch ();
  cfds_out_if out_ch ();

  command_frame_deframer_seq_check DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cfds_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count   (error_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop
  initial begin
    #1_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin : drain
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one byte after a random idle gap and hold it until the transaction
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] dest, input logic [7:0] ftype,
                            input logic [15:0] seq, input logic [31:0] data,
                            input logic [7:0] footer);
    send_byte(HDR_BYTE);
    send_byte(dest);
    send_byte(ftype);
    send_byte(seq[15:8]);
    send_byte(seq[7:0]);
    send_byte(data[31:24]);
    send_byte(data[23:16]);
    send_byte(data[15:8]);
    send_byte(data[7:0]);
    send_byte(footer);
  endtask

  // Drop valid and hold the sender until every expected result has drained
  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (expected_left == 0);
  endtask

  initial begin : stimulus
    logic [SLOT_W-1:0] slot;
    logic [7:0]        ftype;
    logic [7:0]        footer;
    logic [7:0]        noise;
    logic [15:0]       seq;
    logic              known;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    no_gaps       = 1'b0;
    bytes_sent    = 0;
    foreach (last_seq[i]) last_seq[i] = 16'h0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bytes dropped while idle, header value as destination, a match,
    // then a sequence error with extreme data carrying a header value
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(HDR_BYTE, TYPE_STOP, 16'h0001, 32'h0000_0000, FTR_BYTE);
    last_seq[SLOT_STOP] = 16'h0001;
    send_frame(8'h00, TYPE_PUSH, 16'hFFFF, {8'hFF, HDR_BYTE, 8'h00, 8'hFF}, FTR_BYTE);
    last_seq[SLOT_PUSH] = 16'hFFFF;
    drain_wait();

    // Random frames: mostly well formed, some noise, bad footers and unknown types
    while (bytes_sent < RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 5) == 0);

      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do noise = 8'($urandom); while (noise == HDR_BYTE);
          send_byte(noise);
        end
      end

      if ($urandom_range(0, 19) == 0) drain_wait();

      known = ($urandom_range(0, 9) != 0);
      slot = 3'($urandom_range(0, NUM_SLOTS - 1));
      case (slot)
        SLOT_PUSH:  ftype = TYPE_PUSH;
        SLOT_STOP:  ftype = TYPE_STOP;
        SLOT_FWD:   ftype = TYPE_FWD;
        SLOT_BACK:  ftype = TYPE_BACK;
        SLOT_LEFT:  ftype = TYPE_LEFT;
        default:    ftype = TYPE_RIGHT;
      endcase
      if (!known) begin
        do ftype = 8'($urandom);
        while (ftype == TYPE_PUSH || (ftype >= TYPE_STOP && ftype <= TYPE_RIGHT));
      end

      if ($urandom_range(0, 99) < 65) seq = last_seq[slot] + 16'd1;
      else if ($urandom_range(0, 3) == 0) seq = 16'hFFFF;
      else seq = 16'($urandom);

      if ($urandom_range(0, 9) == 0) begin
        do footer = 8'($urandom); while (footer == FTR_BYTE);
      end else begin
        footer = FTR_BYTE;
      end

      send_frame(($urandom_range(0, 7) == 0) ? HDR_BYTE : 8'($urandom), ftype, seq,
                 $urandom, footer);
      if (known && footer == FTR_BYTE) last_seq[slot] = seq;
    end

    drain_wait();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/cfds_pkg.sv
rtl/cfds_if.sv
rtl/cfds_front.sv
rtl/cfds_queue.sv
rtl/cfds_back.sv
rtl/command_frame_deframer_seq_check.sv
dv/cfds_frame_checker.sv
dv/tb_top.sv
